// ===== src/ase_pkg.sv =====
// Shared types and constants for the ascending sort engine.
package ase_pkg;

  // Number of cells in the chain, one stored value per cell.
  localparam int unsigned Capacity = 128;
  // Count width wide enough to hold Capacity itself.
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_UNLOAD = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One request as presented on the input channel.
  typedef struct packed {
    action_e            action;
    logic signed [15:0] load_value;
  } ase_req_t;

  // One result as presented on the output channel.
  typedef struct packed {
    logic signed [15:0] out_value;
    logic               last_flag;
    status_e            status;
  } ase_res_t;

  // Control broadcast to every cell in the chain.
  typedef struct packed {
    logic               load;
    logic               unload;
    logic signed [15:0] value;
  } ase_cell_ctl_t;

endpackage

// ===== src/ascending_sort_engine_unit.sv =====
// Top level of the ascending sort engine: request decode, fill count and cell chain.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// A load request inserts load_value into the sorted chain; an unload request
// removes the smallest stored value and returns it, with last_flag set when
// it was the only one held. Every request gives exactly one result.
// busy is always low: each cell compares the new value against its own and
// shifts in the same edge.
// Throughput is one request per cycle; the result appears on res_o with
// res_valid_o high for exactly one cycle, the cycle after the request.
// The receiver cannot stall, so results are never held back.
// Status reports a load dropped because all cells are full, or an unload of
// an empty chain; in both cases the stored values are left as they are.
// Reset clears the fill count and the result strobe; cell contents are not
// cleared, since only cells below the fill count are ever read.
module ascending_sort_engine_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ase_pkg::ase_req_t req_i,
  output logic              res_valid_o,
  output ase_pkg::ase_res_t res_o
);

  localparam int unsigned Cap  = ase_pkg::Capacity;
  localparam int unsigned CntW = ase_pkg::CntW;

  logic [CntW-1:0]       count_q, count_d;
  logic                  res_valid_q;
  ase_pkg::ase_res_t     res_q, res_d;
  ase_pkg::ase_cell_ctl_t ctl;
  logic                  take;
  logic                  full, empty;

  logic signed [15:0] cell_value [Cap];
  logic               cell_gt    [Cap];

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = (count_q == CntW'(Cap));
  assign empty = (count_q == '0);

  // Decode the request into chain control and the next fill count.
  always_comb begin
    ctl.load   = 1'b0;
    ctl.unload = 1'b0;
    ctl.value  = req_i.load_value;
    count_d    = count_q;
    if (take) begin
      case (req_i.action)
        ase_pkg::ACT_LOAD: begin
          if (!full) begin
            ctl.load = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
        ase_pkg::ACT_UNLOAD: begin
          if (!empty) begin
            ctl.unload = 1'b1;
            count_d    = count_q - CntW'(1);
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Form the result; the smallest value always sits in the first cell.
  always_comb begin
    res_d.out_value = '0;
    res_d.last_flag = 1'b0;
    res_d.status    = ase_pkg::ST_OK;
    case (req_i.action)
      ase_pkg::ACT_LOAD: begin
        if (full) begin
          res_d.status = ase_pkg::ST_FULL;
        end
      end
      ase_pkg::ACT_UNLOAD: begin
        if (empty) begin
          res_d.status = ase_pkg::ST_EMPTY;
        end else begin
          res_d.out_value = cell_value[0];
          res_d.last_flag = (count_q == CntW'(1));
        end
      end
      default: begin
        res_d.status = ase_pkg::ST_OK;
      end
    endcase
  end

  // Chain of cells; each sees its neighbours' values and the insertion flag of the cell below.
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic signed [15:0] prev_value;
    logic               prev_gt;
    logic signed [15:0] next_value;
    logic               occupied;

    if (i == 0) begin : g_first
      assign prev_value = ctl.value;
      assign prev_gt    = 1'b0;
    end else begin : g_inner
      assign prev_value = cell_value[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == Cap - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_body
      assign next_value = cell_value[i+1];
    end

    assign occupied = (CntW'(i) < count_q);

    ase_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occupied_i   (occupied),
      .prev_value_i (prev_value),
      .prev_gt_i    (prev_gt),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // Control state: fill count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= take;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/ase_cell.sv =====
// One cell of the sorting chain: holds a single value and shifts with its neighbours.
module ase_cell (
  input  logic                  clk_i,
  input  ase_pkg::ase_cell_ctl_t ctl_i,
  input  logic                  occupied_i,
  input  logic signed [15:0]    prev_value_i,
  input  logic                  prev_gt_i,
  input  logic signed [15:0]    next_value_i,
  output logic signed [15:0]    value_o,
  output logic                  gt_o
);

  logic signed [15:0] value_q, value_d;

  // An empty cell counts as larger than any new value, so the insertion point
  // is the first cell that is empty or holds a strictly larger value.
  assign gt_o    = !occupied_i || (value_q > ctl_i.value);
  assign value_o = value_q;

  // On a load, cells at and above the insertion point move up by one and the
  // cell at the insertion point takes the new value. On an unload, all move down.
  always_comb begin
    value_d = value_q;
    if (ctl_i.load && gt_o) begin
      value_d = prev_gt_i ? prev_value_i : ctl_i.value;
    end else if (ctl_i.unload) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== bench/tb_ascending_sort_engine_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ascending sort engine: stimulus, model and result checker.
module tb_ascending_sort_engine_unit;

  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ReqW       = $bits(ase_pkg::ase_req_t);

  // Value mixes used by the random episodes.
  typedef enum int {
    MIX_FULL_RANGE,
    MIX_DUPLICATES,
    MIX_EXTREMES
  } value_mix_e;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ase_pkg::ase_req_t req_i;
  logic              res_valid_o;
  ase_pkg::ase_res_t res_o;

  // Model of the store: values held in ascending order, and the results still owed.
  logic signed [15:0] held_values[$];
  ase_pkg::ase_res_t  pending_results[$];

  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned idle_cycles;
  int unsigned loads_taken;
  int unsigned loads_dropped;
  int unsigned values_returned;
  int unsigned empty_unloads;
  int unsigned last_flags_seen;
  int unsigned peak_fill;
  bit          gaps_enabled;

  ascending_sort_engine_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one accepted request and updates the model store.
  function automatic ase_pkg::ase_res_t sort_predict(ase_pkg::ase_req_t r);
    ase_pkg::ase_res_t res;
    int unsigned       pos;
    res.out_value = '0;
    res.last_flag = 1'b0;
    res.status    = ase_pkg::ST_OK;
    if (r.action == ase_pkg::ACT_LOAD) begin
      if (held_values.size() >= ase_pkg::Capacity) begin
        res.status = ase_pkg::ST_FULL;
        loads_dropped++;
      end else begin
        // New values go after any equal values already held.
        pos = 0;
        while (pos < held_values.size() && held_values[pos] <= r.load_value) pos++;
        held_values.insert(pos, r.load_value);
        loads_taken++;
        if (held_values.size() > peak_fill) peak_fill = held_values.size();
      end
    end else begin
      if (held_values.size() == 0) begin
        res.status = ase_pkg::ST_EMPTY;
        empty_unloads++;
      end else begin
        res.last_flag = (held_values.size() == 1);
        res.out_value = held_values.pop_front();
        values_returned++;
        if (res.last_flag) last_flags_seen++;
      end
    end
    return res;
  endfunction

  // Picks the idle time after a request: often none, mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!gaps_enabled || roll < 50) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [15:0] pick_value(value_mix_e mix);
    logic signed [15:0] v;
    case (mix)
      MIX_DUPLICATES: begin
        v = 16'($urandom_range(12)) - 16'sd6;
      end
      MIX_EXTREMES: begin
        case ($urandom_range(6))
          0: v = 16'sh7fff;
          1: v = 16'sh8000;
          2: v = 16'sh7ffe;
          3: v = 16'sh8001;
          4: v = 16'sh0000;
          5: v = 16'shffff;
          default: v = 16'sh0001;
        endcase
      end
      default: begin
        v = 16'($urandom);
      end
    endcase
    return v;
  endfunction

  // Sends one request, waits for it to be taken, then idles for a random time.
  task automatic send_request(ase_pkg::action_e act, logic signed [15:0] value);
    ase_pkg::ase_req_t r;
    int unsigned       gap;
    r.action     = act;
    r.load_value = value;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(sort_predict(r));
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      // Junk on the request bus while start is low must be ignored.
      req_i <= ase_pkg::ase_req_t'(ReqW'($urandom));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_load(logic signed [15:0] value);
    send_request(ase_pkg::ACT_LOAD, value);
  endtask

  task automatic send_unload();
    send_request(ase_pkg::ACT_UNLOAD, 16'($urandom));
  endtask

  // Compares one result against the oldest expectation.
  task automatic check_result(ase_pkg::ase_res_t got);
    ase_pkg::ase_res_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding: out_value %0d last_flag %0b status %0d",
             got.out_value, got.last_flag, got.status);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
        fail_count++;
      end
      if (got.last_flag !== want.last_flag) begin
        $error("last_flag: expected %0b, actual %0b", want.last_flag, got.last_flag);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) check_result(res_o);
  end

  // Watchdog on cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("ascending_sort_engine_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Unloads from an empty store straight after reset.
  task automatic test_empty_unload();
    send_unload();
    send_unload();
  endtask

  // Extreme values, duplicates, the last flag on draining unloads and unloads of an empty store.
  task automatic test_extremes();
    send_load(16'sh7fff);
    send_load(16'sh8000);
    send_load(16'sh0000);
    send_load(16'shffff);
    send_load(16'sh0001);
    send_load(16'sh7fff);
    send_load(16'sh8000);
    send_load(16'sh0000);
    send_unload();
    send_unload();
    send_load(16'sh8000);
    repeat (7) send_unload();
    send_unload();
    send_load(16'sh1234);
    send_unload();
    send_unload();
  endtask

  // Fills the store to capacity, tries to overfill it, then drains it completely.
  task automatic test_fill_and_drain(value_mix_e mix);
    while (held_values.size() < ase_pkg::Capacity) send_load(pick_value(mix));
    send_load(pick_value(mix));
    send_load(pick_value(MIX_EXTREMES));
    while (held_values.size() > 0) send_unload();
    send_unload();
  endtask

  // Random episodes with different load bias, value mix and idling.
  task automatic test_random_mix();
    int unsigned episode_len;
    int unsigned load_pct;
    value_mix_e  mix;
    while (requests_sent < ItemTarget) begin
      episode_len  = $urandom_range(120, 10);
      gaps_enabled = ($urandom_range(3) != 0);
      mix          = value_mix_e'($urandom_range(2));
      case ($urandom_range(3))
        0: load_pct = 85;
        1: load_pct = 55;
        2: load_pct = 30;
        default: load_pct = $urandom_range(100);
      endcase
      repeat (episode_len) begin
        if ($urandom_range(99) < load_pct) send_load(pick_value(mix));
        else send_unload();
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_i           = '0;
    fail_count      = 0;
    requests_sent   = 0;
    idle_cycles     = 0;
    loads_taken     = 0;
    loads_dropped   = 0;
    values_returned = 0;
    empty_unloads   = 0;
    last_flags_seen = 0;
    peak_fill       = 0;
    gaps_enabled    = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_unload();
    test_extremes();
    gaps_enabled = 1'b0;
    test_fill_and_drain(MIX_FULL_RANGE);
    gaps_enabled = 1'b1;
    test_fill_and_drain(MIX_DUPLICATES);
    test_random_mix();

    // Let the last results come through.
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Covered %0d requests: %0d loads stored, %0d loads refused when full,",
             requests_sent, loads_taken, loads_dropped);
    $display("%0d values returned (%0d marked last), %0d empty unloads, peak fill %0d.",
             values_returned, last_flags_seen, empty_unloads, peak_fill);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ascending_sort_engine_unit verification clean");
    end else begin
      $display("ascending_sort_engine_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ase_pkg.sv
src/ase_cell.sv
src/ascending_sort_engine_unit.sv
bench/tb_ascending_sort_engine_unit.sv
